### sv/tacf_pkg.sv
package tacf_pkg;

  // Close phases.
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_EST        = 4'd1,
    PH_FW1        = 4'd2,
    PH_DBL_ACK    = 4'd3,
    PH_DBL_RECV   = 4'd4,
    PH_DBL_FINACK = 4'd5,
    PH_FW2_RECV   = 4'd6,
    PH_FW2_SEND   = 4'd7,
    PH_TIME_WAIT  = 4'd8,
    PH_CLOSED     = 4'd9,
    PH_FAILED     = 4'd10
  } phase_t;

  // Event kinds.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_SEND  = 2'd1;
  localparam logic [1:0] MODE_RECV  = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // Send outcomes. Anything else counts as sent.
  localparam logic [1:0] SS_ERROR = 2'd1;
  localparam logic [1:0] SS_FATAL = 2'd2;

  // Receive outcomes. Anything not listed counts as the awaited segment.
  localparam logic [2:0] RS_DATA    = 3'd1;
  localparam logic [2:0] RS_ERROR   = 3'd2;
  localparam logic [2:0] RS_TIMEOUT = 3'd3;
  localparam logic [2:0] RS_RST     = 3'd4;
  localparam logic [2:0] RS_FINACK  = 3'd5;
  localparam logic [2:0] RS_FATAL   = 3'd6;

  // Commands.
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_FINACK = 3'd1;
  localparam logic [2:0] CMD_ACK    = 3'd2;
  localparam logic [2:0] CMD_RSTACK = 3'd3;
  localparam logic [2:0] CMD_REL    = 3'd4;

  // Awaited segment.
  localparam logic [1:0] AW_NONE   = 2'd0;
  localparam logic [1:0] AW_ACK    = 2'd1;
  localparam logic [1:0] AW_FINACK = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_RETRIES     = 3'd1;
  localparam logic [2:0] ERR_FIN_TIMEOUT = 3'd2;
  localparam logic [2:0] ERR_DOUBLE_FIN  = 3'd3;
  localparam logic [2:0] ERR_RST_ACK     = 3'd4;
  localparam logic [2:0] ERR_RST_FW2     = 3'd5;
  localparam logic [2:0] ERR_RST_TW      = 3'd6;
  localparam logic [2:0] ERR_FATAL       = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_FINACK_RETRIES  = 2'd0;
  localparam logic [1:0] REG_FINACK_WAIT_US  = 2'd1;
  localparam logic [1:0] REG_RECV_TIMEOUT_US = 2'd2;
  localparam logic [1:0] REG_TIME_WAIT_TICKS = 2'd3;

  localparam logic [7:0]  FINACK_RETRIES_RST  = 8'd3;
  localparam logic [31:0] FINACK_WAIT_US_RST  = 32'd1000000;
  localparam logic [31:0] RECV_TIMEOUT_US_RST = 32'd200000;
  localparam logic [15:0] TIME_WAIT_TICKS_RST = 16'd100;

  typedef struct packed {
    logic [7:0]  finack_retries;
    logic [31:0] finack_wait_us;
    logic [31:0] recv_timeout_us;
    logic [15:0] time_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  send_status;
    logic [2:0]  recv_status;
    logic [31:0] peer_seq;
  } item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  awaiting;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [31:0] expected_ack;
    logic        finished;
    logic        success;
    logic [2:0]  error_code;
  } result_t;

endpackage

### sv/tacf_cfg_regs.sv
module tacf_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [31:0]   wr_data,
  output tacf_pkg::cfg_t cfg
);
  import tacf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.finack_retries  <= FINACK_RETRIES_RST;
      cfg.finack_wait_us  <= FINACK_WAIT_US_RST;
      cfg.recv_timeout_us <= RECV_TIMEOUT_US_RST;
      cfg.time_wait_ticks <= TIME_WAIT_TICKS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_FINACK_RETRIES:  cfg.finack_retries  <= wr_data[7:0];
        REG_FINACK_WAIT_US:  cfg.finack_wait_us  <= wr_data;
        REG_RECV_TIMEOUT_US: cfg.recv_timeout_us <= wr_data;
        REG_TIME_WAIT_TICKS: cfg.time_wait_ticks <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/tacf_core.sv
module tacf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  tacf_pkg::item_t   item,
  input  tacf_pkg::cfg_t    cfg,
  output tacf_pkg::result_t result
);
  import tacf_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  retries_left, retries_left_next;
  logic [31:0] fin_wait_left, fin_wait_left_next;
  logic [15:0] time_wait_left, time_wait_left_next;
  logic [31:0] local_seq, local_seq_next;
  logic [31:0] peer_ack, peer_ack_next;
  logic [2:0]  last_error, last_error_next;
  logic [2:0]  command;

  logic [31:0] peer_seq_inc;
  logic        send_fatal;
  logic        send_err;
  logic        recv_fail;

  assign peer_seq_inc = item.peer_seq + 32'd1;
  assign send_fatal   = (item.send_status == SS_FATAL);
  assign send_err     = (item.send_status == SS_ERROR);
  assign recv_fail    = (item.recv_status == RS_ERROR) || (item.recv_status == RS_TIMEOUT);

  // Next state.
  always_comb begin
    phase_next          = phase;
    retries_left_next   = retries_left;
    fin_wait_left_next  = fin_wait_left;
    time_wait_left_next = time_wait_left;
    local_seq_next      = local_seq;
    peer_ack_next       = peer_ack;
    last_error_next     = last_error;
    case (item.mode)
      MODE_START: begin
        local_seq_next      = item.peer_seq;
        retries_left_next   = cfg.finack_retries;
        fin_wait_left_next  = cfg.finack_wait_us;
        time_wait_left_next = '0;
        last_error_next     = ERR_NONE;
        phase_next          = PH_EST;
      end
      MODE_SEND: begin
        if (send_fatal && (phase == PH_EST || phase == PH_DBL_ACK ||
            phase == PH_DBL_FINACK || phase == PH_FW2_SEND || phase == PH_TIME_WAIT)) begin
          last_error_next = ERR_FATAL;
          phase_next      = PH_FAILED;
        end else begin
          case (phase)
            PH_EST: begin
              if (!send_err) phase_next = PH_FW1;
            end
            PH_DBL_ACK: begin
              if (send_err) last_error_next = ERR_DOUBLE_FIN;
              else phase_next = PH_DBL_RECV;
            end
            PH_DBL_FINACK: begin
              last_error_next = ERR_DOUBLE_FIN;
              phase_next      = PH_DBL_ACK;
            end
            PH_FW2_SEND: begin
              if (!send_err) begin
                time_wait_left_next = cfg.time_wait_ticks;
                phase_next          = PH_TIME_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      MODE_RECV: begin
        if (item.recv_status == RS_FATAL && (phase == PH_FW1 || phase == PH_DBL_RECV ||
            phase == PH_FW2_RECV || phase == PH_TIME_WAIT)) begin
          last_error_next = ERR_FATAL;
          phase_next      = PH_FAILED;
        end else begin
          case (phase)
            PH_FW1, PH_DBL_RECV: begin
              if (item.recv_status == RS_FINACK ||
                  (phase == PH_DBL_RECV && item.recv_status == RS_DATA)) begin
                if (item.recv_status == RS_FINACK) peer_ack_next = peer_seq_inc;
                last_error_next = ERR_DOUBLE_FIN;
                phase_next      = PH_DBL_ACK;
              end else if (recv_fail) begin
                // Our FIN|ACK went unanswered: resend while the budget lasts.
                if (retries_left == '0) begin
                  last_error_next = ERR_RETRIES;
                  phase_next      = PH_FAILED;
                end else begin
                  retries_left_next = retries_left - 8'd1;
                  phase_next = (phase == PH_FW1) ? PH_EST : PH_DBL_FINACK;
                end
              end else if (item.recv_status == RS_RST) begin
                last_error_next = ERR_RST_ACK;
                phase_next      = PH_CLOSED;
              end else if (item.recv_status != RS_DATA) begin
                local_seq_next = local_seq + 32'd1;
                if (phase == PH_FW1) begin
                  phase_next = PH_FW2_RECV;
                end else begin
                  time_wait_left_next = cfg.time_wait_ticks;
                  phase_next          = PH_TIME_WAIT;
                end
              end
            end
            PH_FW2_RECV: begin
              if (recv_fail) begin
                if (fin_wait_left != '0) begin
                  fin_wait_left_next = (fin_wait_left > cfg.recv_timeout_us) ?
                                       fin_wait_left - cfg.recv_timeout_us : '0;
                end else begin
                  last_error_next = ERR_FIN_TIMEOUT;
                  phase_next      = PH_CLOSED;
                end
              end else if (item.recv_status == RS_RST) begin
                last_error_next = ERR_RST_FW2;
                phase_next      = PH_CLOSED;
              end else if (item.recv_status != RS_DATA) begin
                peer_ack_next = peer_seq_inc;
                phase_next    = PH_FW2_SEND;
              end
            end
            PH_TIME_WAIT: begin
              if (item.recv_status == RS_RST) begin
                last_error_next = ERR_RST_TW;
                phase_next      = PH_CLOSED;
              end
            end
            default: ;
          endcase
        end
      end
      default: begin
        if (phase == PH_TIME_WAIT) begin
          if (time_wait_left <= 16'd1) begin
            time_wait_left_next = '0;
            phase_next          = PH_CLOSED;
          end else begin
            time_wait_left_next = time_wait_left - 16'd1;
          end
        end
      end
    endcase
  end

  // Outputs.
  always_comb begin
    command = CMD_NONE;
    case (item.mode)
      MODE_START: command = CMD_FINACK;
      MODE_SEND: begin
        if (!send_fatal) begin
          case (phase)
            PH_EST:        if (send_err) command = CMD_FINACK;
            PH_DBL_ACK:    if (send_err) command = CMD_ACK;
            PH_DBL_FINACK: command = CMD_ACK;
            PH_FW2_SEND:   if (send_err) command = CMD_ACK;
            default: ;
          endcase
        end
      end
      MODE_RECV: begin
        if (item.recv_status != RS_FATAL) begin
          case (phase)
            PH_FW1, PH_DBL_RECV: begin
              if (item.recv_status == RS_FINACK ||
                  (phase == PH_DBL_RECV && item.recv_status == RS_DATA)) begin
                command = CMD_ACK;
              end else if (recv_fail) begin
                if (retries_left != '0) command = CMD_FINACK;
              end else if (item.recv_status == RS_RST) begin
                command = CMD_REL;
              end
            end
            PH_FW2_RECV: begin
              if (recv_fail) begin
                if (fin_wait_left == '0) command = CMD_RSTACK;
              end else if (item.recv_status == RS_RST) begin
                command = CMD_REL;
              end else if (item.recv_status != RS_DATA) begin
                command = CMD_ACK;
              end
            end
            PH_TIME_WAIT: begin
              // A repeated FIN|ACK means our last ACK was lost.
              if (item.recv_status == RS_RST) command = CMD_REL;
              else if (item.recv_status != RS_DATA && !recv_fail) command = CMD_ACK;
            end
            default: ;
          endcase
        end
      end
      default: begin
        if (phase == PH_TIME_WAIT && time_wait_left <= 16'd1) command = CMD_REL;
      end
    endcase

    result.command = command;
    if (phase_next == PH_FW1 || phase_next == PH_DBL_RECV) result.awaiting = AW_ACK;
    else if (phase_next == PH_FW2_RECV || phase_next == PH_TIME_WAIT) result.awaiting = AW_FINACK;
    else result.awaiting = AW_NONE;
    result.seq_out      = local_seq_next;
    result.ack_out      = peer_ack_next;
    result.expected_ack = local_seq_next + 32'd1;
    result.finished     = (phase_next == PH_CLOSED) || (phase_next == PH_FAILED);
    result.success      = (phase_next == PH_CLOSED);
    result.error_code   = last_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      retries_left   <= '0;
      fin_wait_left  <= '0;
      time_wait_left <= '0;
      local_seq      <= '0;
      peer_ack       <= '0;
      last_error     <= ERR_NONE;
    end else if (item_valid) begin
      phase          <= phase_next;
      retries_left   <= retries_left_next;
      fin_wait_left  <= fin_wait_left_next;
      time_wait_left <= time_wait_left_next;
      local_seq      <= local_seq_next;
      peer_ack       <= peer_ack_next;
      last_error     <= last_error_next;
    end
  end

`ifndef SYNTHESIS
  a_start_enters_est: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.mode == MODE_START |=> phase == PH_EST)
    else $error("start transaction did not enter the established phase");

  a_retries_only_drop: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.mode != MODE_START |=> retries_left <= $past(retries_left))
    else $error("retry budget grew without a start");

  a_time_wait_load: assert property (@(posedge clk) disable iff (rst)
    item_valid && phase != PH_TIME_WAIT && phase_next == PH_TIME_WAIT
    |=> time_wait_left == $past(cfg.time_wait_ticks))
    else $error("TIME-WAIT entered without loading the tick count");

  a_closed_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CLOSED || phase == PH_FAILED) && !(item_valid && item.mode == MODE_START)
    |=> phase == $past(phase))
    else $error("left a final phase without a start");
`endif

endmodule

### sv/tcp_active_close_fsm_unit.sv
// A transaction accepted into the input register passes through the close FSM, and its
// result is registered in the output register that drives m_tdata once that has room.
// Throughput: one event per clock when the output side does not stall. A result
// waiting on m_tready does not stop one more event being taken.
// Reset (rst, synchronous): phase idle, all counters and numbers zero, configuration
// registers at their default values, both stream sides empty.
module tcp_active_close_fsm_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,   // send_status, recv_status, peer_seq, zero fill
  input  logic [1:0]    s_tuser,   // mode
  output logic          m_tvalid,
  input  logic          m_tready,
  // command, awaiting, seq_out, ack_out, expected_ack, finished, success, error_code,
  // zero fill
  output logic [111:0]  m_tdata,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [31:0]   wr_data
);
  import tacf_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  logic    advance;
  cfg_t    cfg;
  result_t result;

  // The held item is processed once the output register has room for its result.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode        <= s_tuser;
      in_item.send_status <= s_tdata[1:0];
      in_item.recv_status <= s_tdata[4:2];
      in_item.peer_seq    <= s_tdata[36:5];
    end
  end

  tacf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  tacf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .item       (in_item),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid         = out_valid;
  assign m_tdata[2:0]     = out_result.command;
  assign m_tdata[4:3]     = out_result.awaiting;
  assign m_tdata[36:5]    = out_result.seq_out;
  assign m_tdata[68:37]   = out_result.ack_out;
  assign m_tdata[100:69]  = out_result.expected_ack;
  assign m_tdata[101]     = out_result.finished;
  assign m_tdata[102]     = out_result.success;
  assign m_tdata[105:103] = out_result.error_code;
  assign m_tdata[111:106] = '0;

endmodule

### dv/tb_tcp_active_close_fsm_unit.sv
`timescale 1ns / 1ps

module tb_tcp_active_close_fsm_unit;
  import tacf_pkg::*;

  // Status values that the package leaves unnamed; both count as success.
  localparam logic [1:0] SS_SENT        = 2'd0;
  localparam logic [1:0] SS_SENT_ALT    = 2'd3;
  localparam logic [2:0] RS_AWAITED     = 3'd0;
  localparam logic [2:0] RS_AWAITED_ALT = 3'd7;

  localparam int IDLE_PCT       = 25;
  localparam int HOLD_CYCLES    = 80;
  localparam int STALL_LIMIT    = 1000;
  localparam int RAND_PER_PHASE = 185;

  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [39:0]   s_tdata;   // send_status, recv_status, peer_seq, zero fill
  logic [1:0]    s_tuser;   // mode
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  // command, awaiting, seq_out, ack_out, expected_ack, finished, success, error_code,
  // zero fill
  logic [111:0]  m_tdata;
  logic          wr_en    = 1'b0;
  logic [1:0]    wr_index = '0;
  logic [31:0]   wr_data  = '0;

  item_t cur_item = '0;
  logic  burst    = 1'b0;
  logic  hold_req = 1'b0;

  assign s_tdata = {3'b000, cur_item.peer_seq, cur_item.recv_status, cur_item.send_status};
  assign s_tuser = cur_item.mode;

  tcp_active_close_fsm_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mirror of the close controller, advanced once per accepted event.
  cfg_t        cfg;
  phase_t      cl_phase;
  logic [7:0]  cl_retries;
  logic [31:0] cl_fw_budget;
  logic [15:0] cl_tw_count;
  logic [31:0] cl_seq;
  logic [31:0] cl_ack;
  logic [2:0]  cl_err;

  item_t   event_q[$];
  result_t outcome_q[$];

  int events_taken = 0;
  int results_seen = 0;
  int err_count    = 0;
  int settings_run = 0;

  function automatic logic [2:0] enter_double();
    cl_err   = ERR_DOUBLE_FIN;
    cl_phase = PH_DBL_ACK;
    return CMD_ACK;
  endfunction

  // Receive error or timeout while our FIN|ACK still waits for its ACK.
  function automatic logic [2:0] spend_retry(phase_t nxt);
    if (cl_retries == 8'd0) begin
      cl_err   = ERR_RETRIES;
      cl_phase = PH_FAILED;
      return CMD_NONE;
    end
    cl_retries = cl_retries - 8'd1;
    cl_phase   = nxt;
    return CMD_FINACK;
  endfunction

  function automatic result_t close_step(item_t ev);
    result_t    r;
    logic [2:0] cmd;
    logic       snd_err;
    cmd     = CMD_NONE;
    snd_err = (ev.send_status == SS_ERROR);
    case (ev.mode)
      MODE_START: begin
        cl_seq       = ev.peer_seq;
        cl_retries   = cfg.finack_retries;
        cl_fw_budget = cfg.finack_wait_us;
        cl_tw_count  = '0;
        cl_err       = ERR_NONE;
        cl_phase     = PH_EST;
        cmd          = CMD_FINACK;
      end
      MODE_SEND: begin
        if (ev.send_status == SS_FATAL) begin
          if (cl_phase inside {PH_EST, PH_DBL_ACK, PH_DBL_FINACK, PH_FW2_SEND,
                               PH_TIME_WAIT}) begin
            cl_err   = ERR_FATAL;
            cl_phase = PH_FAILED;
          end
        end else begin
          case (cl_phase)
            PH_EST: begin
              if (snd_err) cmd = CMD_FINACK;
              else cl_phase = PH_FW1;
            end
            PH_DBL_ACK: begin
              if (snd_err) cmd = enter_double();
              else cl_phase = PH_DBL_RECV;
            end
            PH_DBL_FINACK: cmd = enter_double();
            PH_FW2_SEND: begin
              if (snd_err) begin
                cmd = CMD_ACK;
              end else begin
                cl_tw_count = cfg.time_wait_ticks;
                cl_phase    = PH_TIME_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      MODE_RECV: begin
        if (cl_phase inside {PH_FW1, PH_DBL_RECV, PH_FW2_RECV, PH_TIME_WAIT}) begin
          if (ev.recv_status == RS_FATAL) begin
            cl_err   = ERR_FATAL;
            cl_phase = PH_FAILED;
          end else if (ev.recv_status == RS_RST) begin
            if (cl_phase == PH_FW2_RECV) cl_err = ERR_RST_FW2;
            else if (cl_phase == PH_TIME_WAIT) cl_err = ERR_RST_TW;
            else cl_err = ERR_RST_ACK;
            cl_phase = PH_CLOSED;
            cmd      = CMD_REL;
          end else begin
            case (cl_phase)
              PH_FW1, PH_DBL_RECV: begin
                if (ev.recv_status == RS_FINACK) begin
                  cl_ack = ev.peer_seq + 32'd1;
                  cmd    = enter_double();
                end else if (ev.recv_status == RS_DATA) begin
                  if (cl_phase == PH_DBL_RECV) cmd = enter_double();
                end else if (ev.recv_status inside {RS_ERROR, RS_TIMEOUT}) begin
                  cmd = spend_retry(cl_phase == PH_FW1 ? PH_EST : PH_DBL_FINACK);
                end else begin
                  cl_seq = cl_seq + 32'd1;
                  if (cl_phase == PH_FW1) begin
                    cl_phase = PH_FW2_RECV;
                  end else begin
                    cl_tw_count = cfg.time_wait_ticks;
                    cl_phase    = PH_TIME_WAIT;
                  end
                end
              end
              PH_FW2_RECV: begin
                if (ev.recv_status inside {RS_ERROR, RS_TIMEOUT}) begin
                  if (cl_fw_budget != 32'd0) begin
                    cl_fw_budget = (cl_fw_budget > cfg.recv_timeout_us) ?
                                   cl_fw_budget - cfg.recv_timeout_us : 32'd0;
                  end else begin
                    cl_err   = ERR_FIN_TIMEOUT;
                    cl_phase = PH_CLOSED;
                    cmd      = CMD_RSTACK;
                  end
                end else if (ev.recv_status != RS_DATA) begin
                  cl_ack   = ev.peer_seq + 32'd1;
                  cl_phase = PH_FW2_SEND;
                  cmd      = CMD_ACK;
                end
              end
              default: begin
                // TIME-WAIT: a repeated FIN|ACK or the awaited code is answered again.
                if (!(ev.recv_status inside {RS_DATA, RS_ERROR, RS_TIMEOUT})) cmd = CMD_ACK;
              end
            endcase
          end
        end
      end
      default: begin
        if (cl_phase == PH_TIME_WAIT) begin
          if (cl_tw_count <= 16'd1) begin
            cl_tw_count = '0;
            cl_phase    = PH_CLOSED;
            cmd         = CMD_REL;
          end else begin
            cl_tw_count = cl_tw_count - 16'd1;
          end
        end
      end
    endcase

    r.command = cmd;
    if (cl_phase inside {PH_FW1, PH_DBL_RECV}) r.awaiting = AW_ACK;
    else if (cl_phase inside {PH_FW2_RECV, PH_TIME_WAIT}) r.awaiting = AW_FINACK;
    else r.awaiting = AW_NONE;
    r.seq_out      = cl_seq;
    r.ack_out      = cl_ack;
    r.expected_ack = cl_seq + 32'd1;
    r.finished     = (cl_phase inside {PH_CLOSED, PH_FAILED});
    r.success      = (cl_phase == PH_CLOSED);
    r.error_code   = cl_err;
    return r;
  endfunction

  // Sender: offers queued events, and predicts the outcome of each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid     <= 1'b0;
      cfg          = {FINACK_RETRIES_RST, FINACK_WAIT_US_RST, RECV_TIMEOUT_US_RST,
                      TIME_WAIT_TICKS_RST};
      cl_phase     = PH_IDLE;
      cl_retries   = '0;
      cl_fw_budget = '0;
      cl_tw_count  = '0;
      cl_seq       = '0;
      cl_ack       = '0;
      cl_err       = ERR_NONE;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_FINACK_RETRIES:  cfg.finack_retries  = wr_data[7:0];
          REG_FINACK_WAIT_US:  cfg.finack_wait_us  = wr_data;
          REG_RECV_TIMEOUT_US: cfg.recv_timeout_us = wr_data;
          default:             cfg.time_wait_ticks = wr_data[15:0];
        endcase
      end
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(close_step(cur_item));
        events_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (event_q.size() != 0 && (burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_item <= event_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off so the block backs up.
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        $error("result transaction arrived with no outcome pending");
        err_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("command",      32'(want.command),    32'(m_tdata[2:0]));
        check_field("awaiting",     32'(want.awaiting),   32'(m_tdata[4:3]));
        check_field("seq_out",      want.seq_out,         m_tdata[36:5]);
        check_field("ack_out",      want.ack_out,         m_tdata[68:37]);
        check_field("expected_ack", want.expected_ack,    m_tdata[100:69]);
        check_field("finished",     32'(want.finished),   32'(m_tdata[101]));
        check_field("success",      32'(want.success),    32'(m_tdata[102]));
        check_field("error_code",   32'(want.error_code), 32'(m_tdata[105:103]));
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[tcp_active_close_fsm_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t mk(logic [1:0] mode, logic [1:0] ss, logic [2:0] rs,
                               logic [31:0] seq);
    item_t it;
    it.mode        = mode;
    it.send_status = ss;
    it.recv_status = rs;
    it.peer_seq    = seq;
    return it;
  endfunction

  function automatic item_t rand_event();
    int          p;
    int          q;
    logic [1:0]  mode;
    logic [1:0]  ss;
    logic [2:0]  rs;
    logic [31:0] seq;
    p = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    if (p < 3) mode = MODE_START;
    else if (p < 40) mode = MODE_SEND;
    else if (p < 85) mode = MODE_RECV;
    else mode = MODE_TICK;
    if (q < 72) ss = SS_SENT;
    else if (q < 78) ss = SS_SENT_ALT;
    else if (q < 95) ss = SS_ERROR;
    else ss = SS_FATAL;
    q = $urandom_range(0, 99);
    if (q < 42) rs = RS_AWAITED;
    else if (q < 47) rs = RS_AWAITED_ALT;
    else if (q < 57) rs = RS_DATA;
    else if (q < 66) rs = RS_ERROR;
    else if (q < 75) rs = RS_TIMEOUT;
    else if (q < 79) rs = RS_RST;
    else if (q < 95) rs = RS_FINACK;
    else rs = RS_FATAL;
    seq = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
    return mk(mode, ss, rs, seq);
  endfunction

  // Mostly complete close attempts with random content, some loose events between.
  task automatic queue_sessions(int n);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        event_q.push_back(rand_event());
        cnt++;
      end else begin
        event_q.push_back(mk(MODE_START, SS_SENT, RS_AWAITED,
                             ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom));
        len = $urandom_range(3, 24);
        repeat (len) event_q.push_back(rand_event());
        cnt += len + 1;
      end
    end
  endtask

  // Waits until every outcome has been checked and the block is quiet.
  task automatic wait_idle();
    while (event_q.size() != 0 || s_tvalid || outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] retries, logic [31:0] wait_us,
                            logic [31:0] timeout_us, logic [15:0] tw_ticks);
    write_reg(REG_FINACK_RETRIES, {24'd0, retries});
    write_reg(REG_FINACK_WAIT_US, wait_us);
    write_reg(REG_RECV_TIMEOUT_US, timeout_us);
    write_reg(REG_TIME_WAIT_TICKS, {16'd0, tw_ticks});
    settings_run++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through the close phases with a tight budget and one retry.
    set_config(8'd1, 32'd400, 32'd200, 16'd2);
    event_q.push_back(mk(MODE_TICK,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_FINACK,      32'hFFFF_FFFF));
    event_q.push_back(mk(MODE_START, SS_SENT,     RS_AWAITED,     32'hFFFF_FFFF));
    event_q.push_back(mk(MODE_SEND,  SS_ERROR,    RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_SENT_ALT, RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_TIMEOUT,     32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_ERROR,       32'd0));
    event_q.push_back(mk(MODE_START, SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_AWAITED_ALT, 32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_DATA,        32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_TIMEOUT,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_ERROR,       32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_TIMEOUT,     32'd0));
    event_q.push_back(mk(MODE_START, SS_SENT,     RS_AWAITED,     32'h8000_0000));
    event_q.push_back(mk(MODE_SEND,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_FINACK,      32'hFFFF_FFFF));
    event_q.push_back(mk(MODE_SEND,  SS_ERROR,    RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_DATA,        32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_TIMEOUT,     32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_RECV,  SS_SENT,     RS_FINACK,      32'h7FFF_FFFF));
    event_q.push_back(mk(MODE_TICK,  SS_SENT,     RS_AWAITED,     32'd0));
    event_q.push_back(mk(MODE_SEND,  SS_FATAL,    RS_AWAITED,     32'd0));
    wait_idle();

    // Lowest settings: no retries, no FIN-wait-2 budget, TIME-WAIT ends on first tick.
    set_config(8'd0, 32'd0, 32'd0, 16'd0);
    queue_sessions(RAND_PER_PHASE);
    wait_idle();

    // Highest retry, wait and timeout settings with a one-tick TIME-WAIT, plus the long receiver hold-off.
    set_config(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
    hold_req <= 1'b1;
    queue_sessions(RAND_PER_PHASE);
    wait_idle();

    // Budget that saturates after a few timeouts, with no idling on either side.
    set_config(8'd2, 32'd1000, 32'd300, 16'd3);
    burst <= 1'b1;
    queue_sessions(RAND_PER_PHASE);
    wait_idle();
    burst <= 1'b0;

    set_config(FINACK_RETRIES_RST, FINACK_WAIT_US_RST, RECV_TIMEOUT_US_RST, 16'hFFFF);
    queue_sessions(RAND_PER_PHASE);
    wait_idle();

    if (outcome_q.size() != 0) begin
      $error("%0d outcomes never arrived", outcome_q.size());
      err_count++;
    end
    $display("Ran %0d close events across %0d register settings; %0d results checked.",
             events_taken, settings_run, results_seen);
    $display("Both sides stalled at random, with one long output hold-off.");
    if (err_count == 0) begin
      $display("[tcp_active_close_fsm_unit] OK");
    end else begin
      $display("[tcp_active_close_fsm_unit] ERROR");
    end
    $finish;
  end

endmodule
